FILE: hdl/crockford_base32_encoder_assert.svh
`ifndef CROCKFORD_BASE32_ENCODER_ASSERT_SVH
`define CROCKFORD_BASE32_ENCODER_ASSERT_SVH

// check outside reset
`define CB32ENC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check at every edge, reset included
`define CB32ENC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hdl/cb32enc_pkg.sv
`default_nettype none

package cb32enc_pkg;

  localparam int unsigned GroupW  = 5;
  localparam int unsigned SymW    = 7;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned MaxSyms = 3;

  typedef enum logic [2:0] {
    PH_0 = 3'd0,
    PH_1 = 3'd1,
    PH_2 = 3'd2,
    PH_3 = 3'd3,
    PH_4 = 3'd4
  } phase_e;

  typedef logic [GroupW-1:0] group_t;
  typedef logic [SymW-1:0]   sym_t;

  localparam sym_t Alphabet [32] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46,
    7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4D, 7'h4E, 7'h50, 7'h51,
    7'h52, 7'h53, 7'h54, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A
  };

endpackage

`default_nettype wire

FILE: hdl/crockford_base32_encoder.sv
`default_nettype none
// Path: a byte's groups go to the group buffer, then each symbol to the output register.
// Throughput: one symbol per cycle while the output is not stalled; a byte makes
// one or two symbols (three for a last byte with a pending group), and the
// next byte enters in the cycle its predecessor's final symbol leaves the buffer.
// Reset: rst_ni clears phase, carry, buffer count and output valid at once.
module crockford_base32_encoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  wire logic       s_axis_tlast,   // end_of_message
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [6:0] symbol, [7] zero
  output logic            m_axis_tlast    // last_symbol
);

  cb32enc_pkg::phase_e phase_q, phase_d;
  cb32enc_pkg::group_t carry_q, carry_d;

  cb32enc_pkg::group_t grp_q [cb32enc_pkg::MaxSyms];
  cb32enc_pkg::group_t grp_d [cb32enc_pkg::MaxSyms];
  logic [1:0] cnt_q, cnt_d, nsym;
  logic [1:0] ptr_q, ptr_d;
  logic       last_q, last_d;

  logic                   out_vld_q, out_vld_d;
  cb32enc_pkg::sym_t      out_sym_q, out_sym_d;
  logic                   out_last_q, out_last_d;

  logic                          acc, pop;
  logic [cb32enc_pkg::ByteW-1:0] c;
  cb32enc_pkg::phase_e           ph_nxt;
  cb32enc_pkg::group_t           cb_nxt;
  cb32enc_pkg::group_t           g0, g1, g2;
  logic [1:0]                    n_base;

  assign c   = s_axis_tdata;
  assign pop = (cnt_q != 2'd0) && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
  assign acc = s_axis_tvalid && s_axis_tready;

  // split the byte into groups
  always_comb begin
    g0     = '0;
    g1     = '0;
    g2     = '0;
    n_base = 2'd1;
    cb_nxt = '0;
    ph_nxt = cb32enc_pkg::PH_0;
    case (phase_q)
      cb32enc_pkg::PH_1: begin
        g0     = carry_q | {3'b000, c[7:6]};
        g1     = c[5:1];
        n_base = 2'd2;
        cb_nxt = {c[0], 4'b0000};
        ph_nxt = cb32enc_pkg::PH_2;
      end
      cb32enc_pkg::PH_2: begin
        g0     = carry_q | {1'b0, c[7:4]};
        cb_nxt = {c[3:0], 1'b0};
        ph_nxt = cb32enc_pkg::PH_3;
      end
      cb32enc_pkg::PH_3: begin
        g0     = carry_q | {4'b0000, c[7]};
        g1     = c[6:2];
        n_base = 2'd2;
        cb_nxt = {c[1:0], 3'b000};
        ph_nxt = cb32enc_pkg::PH_4;
      end
      cb32enc_pkg::PH_4: begin
        g0     = carry_q | {2'b00, c[7:5]};
        g1     = c[4:0];
        n_base = 2'd2;
      end
      default: begin
        g0     = c[7:3];
        cb_nxt = {c[2:0], 2'b00};
        ph_nxt = cb32enc_pkg::PH_1;
      end
    endcase
    nsym = n_base;
    if (s_axis_tlast && (ph_nxt != cb32enc_pkg::PH_0)) begin
      nsym = n_base + 2'd1;
      if (n_base == 2'd1) begin
        g1 = cb_nxt;
      end else begin
        g2 = cb_nxt;
      end
    end
  end

  always_comb begin
    phase_d = phase_q;
    carry_d = carry_q;
    grp_d   = grp_q;
    cnt_d   = cnt_q;
    ptr_d   = ptr_q;
    last_d  = last_q;
    if (pop) begin
      cnt_d = cnt_q - 2'd1;
      ptr_d = ptr_q + 2'd1;
    end
    if (acc) begin
      grp_d[0] = g0;
      grp_d[1] = g1;
      grp_d[2] = g2;
      cnt_d    = nsym;
      ptr_d    = 2'd0;
      last_d   = s_axis_tlast;
      phase_d  = s_axis_tlast ? cb32enc_pkg::PH_0 : ph_nxt;
      carry_d  = s_axis_tlast ? '0 : cb_nxt;
    end
  end

  // output stage: advance on pop, drop when taken
  always_comb begin
    out_vld_d  = out_vld_q;
    out_sym_d  = out_sym_q;
    out_last_d = out_last_q;
    if (pop) begin
      out_vld_d  = 1'b1;
      out_sym_d  = cb32enc_pkg::Alphabet[grp_q[ptr_q]];
      out_last_d = last_q && (cnt_q == 2'd1);
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= cb32enc_pkg::PH_0;
      carry_q   <= '0;
      cnt_q     <= 2'd0;
      ptr_q     <= 2'd0;
      out_vld_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      carry_q   <= carry_d;
      cnt_q     <= cnt_d;
      ptr_q     <= ptr_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q      <= grp_d;
    last_q     <= last_d;
    out_sym_q  <= out_sym_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_sym_q};
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

FILE: hdl/cb32enc_checker.sv
`default_nettype none
`include "crockford_base32_encoder_assert.svh"

module cb32enc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic [7:0] s_axis_tdata,
  input wire logic       s_axis_tlast,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast
);

  logic in_beat;
  logic sym_ok;

  assign in_beat = s_axis_tvalid && s_axis_tready;
  assign sym_ok  = (m_axis_tdata >= 8'h30) && (m_axis_tdata <= 8'h5A) &&
                   !((m_axis_tdata >= 8'h3A) && (m_axis_tdata <= 8'h40)) &&
                   (m_axis_tdata != 8'h49) && (m_axis_tdata != 8'h4C) &&
                   (m_axis_tdata != 8'h4F) && (m_axis_tdata != 8'h55);

  `CB32ENC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output beat changed while stalled")
  `CB32ENC_ASSERT(a_sym_valid, m_axis_tvalid |-> sym_ok, "symbol outside the alphabet")
  `CB32ENC_ASSERT(a_in_to_out, in_beat |-> ##2 m_axis_tvalid, "input beat produced no output")
  `CB32ENC_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> !m_axis_tvalid, "output valid during reset")

  logic unused_ok;
  assign unused_ok = ^{s_axis_tdata, s_axis_tlast};

endmodule

bind crockford_base32_encoder cb32enc_checker u_cb32enc_checker (.*);

`default_nettype wire

FILE: bench/crockford_base32_encoder_test.sv
module crockford_base32_encoder_test;

  typedef struct packed {
    logic [7:0] data_b;
    logic       eom;
  } in_beat_t;

  typedef struct packed {
    cb32enc_pkg::sym_t symbol;
    logic              last_sym;
  } sym_beat_t;

  localparam int IdleLimit  = 2000;
  localparam int HoldCycles = 240;
  localparam int HoldAfter  = 40;
  localparam int DrainWait  = 8;
  localparam int TargetBytes = 400;

  logic       clk_i;
  logic       rst_ni  = 1'b0;
  logic       s_valid = 1'b0;
  logic       s_ready;
  logic [7:0] s_data  = 8'h00;
  logic       s_last  = 1'b0;
  logic       m_valid;
  logic       m_ready = 1'b0;
  logic [7:0] m_data;
  logic       m_last;

  in_beat_t  bytes_pending [$];
  sym_beat_t symbols_due [$];

  cb32enc_pkg::phase_e enc_phase = cb32enc_pkg::PH_0;
  cb32enc_pkg::group_t enc_carry = '0;

  int        mismatches  = 0;
  int        idle_cycles = 0;
  int        beats_out   = 0;
  bit        in_taken    = 1'b0;
  int        send_gap    = 0;
  int        send_calm   = 0;
  int        recv_stall  = 0;
  int        recv_calm   = 0;
  int        hold_left   = 0;
  bit        held        = 1'b0;
  in_beat_t  next_beat;
  sym_beat_t due;
  int        queued_bytes = 0;

  crockford_base32_encoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tlast  (m_last)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic cb32enc_pkg::sym_t crock_char(input cb32enc_pkg::group_t g);
    logic [7:0] c;
    if (g < 5'd10) begin
      c = 8'h30 + {3'b000, g};
    end else begin
      c = 8'h41 + {3'b000, g} - 8'd10;
      if (c >= "I") c = c + 8'd1;
      if (c >= "L") c = c + 8'd1;
      if (c >= "O") c = c + 8'd1;
      if (c >= "U") c = c + 8'd1;
    end
    return c[6:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic encode_byte(input logic [7:0] c, input logic eom);
    cb32enc_pkg::group_t groups [3];
    int                  n;
    cb32enc_pkg::group_t carry_n;
    cb32enc_pkg::phase_e phase_n;
    sym_beat_t           sb;
    n = 0;
    case (enc_phase)
      cb32enc_pkg::PH_0: begin
        groups[0] = c[7:3];
        n = 1;
        carry_n = {c[2:0], 2'b00};
        phase_n = cb32enc_pkg::PH_1;
      end
      cb32enc_pkg::PH_1: begin
        groups[0] = {enc_carry[4:2], c[7:6]};
        groups[1] = c[5:1];
        n = 2;
        carry_n = {c[0], 4'b0000};
        phase_n = cb32enc_pkg::PH_2;
      end
      cb32enc_pkg::PH_2: begin
        groups[0] = {enc_carry[4], c[7:4]};
        n = 1;
        carry_n = {c[3:0], 1'b0};
        phase_n = cb32enc_pkg::PH_3;
      end
      cb32enc_pkg::PH_3: begin
        groups[0] = {enc_carry[4:1], c[7]};
        groups[1] = c[6:2];
        n = 2;
        carry_n = {c[1:0], 3'b000};
        phase_n = cb32enc_pkg::PH_4;
      end
      default: begin
        groups[0] = {enc_carry[4:3], c[7:5]};
        groups[1] = c[4:0];
        n = 2;
        carry_n = '0;
        phase_n = cb32enc_pkg::PH_0;
      end
    endcase
    if (eom) begin
      if (phase_n != cb32enc_pkg::PH_0) begin
        groups[n] = carry_n;
        n++;
      end
      phase_n = cb32enc_pkg::PH_0;
      carry_n = '0;
    end
    for (int i = 0; i < n; i++) begin
      sb.symbol   = crock_char(groups[i]);
      sb.last_sym = eom && (i == n - 1);
      symbols_due.push_back(sb);
    end
    enc_phase = phase_n;
    enc_carry = carry_n;
  endtask

  task automatic push_beat(input logic [7:0] d, input logic eom);
    in_beat_t b;
    b.data_b = d;
    b.eom    = eom;
    bytes_pending.push_back(b);
    queued_bytes++;
  endtask

  task automatic push_message(input int len);
    logic [7:0] d;
    int         r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) d = 8'h00;
      else if (r == 1) d = 8'hFF;
      else d = 8'($urandom_range(0, 255));
      push_beat(d, i == len - 1);
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && (!s_valid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_valid <= 1'b0;
      end else if (bytes_pending.size() > 0) begin
        next_beat = bytes_pending.pop_front();
        s_valid <= 1'b1;
        s_data  <= next_beat.data_b;
        s_last  <= next_beat.eom;
        if (send_calm > 0) begin
          send_calm--;
          send_gap = 0;
        end else begin
          send_gap = pick_gap();
          if ($urandom_range(0, 59) == 0) send_calm = $urandom_range(20, 60);
        end
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!held && beats_out >= HoldAfter) begin
      held = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
      if (recv_calm > 0) begin
        recv_calm--;
      end else begin
        if ($urandom_range(0, 2) == 0) recv_stall = pick_gap();
        if ($urandom_range(0, 99) == 0) recv_calm = $urandom_range(20, 60);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= s_valid && s_ready;
      if (s_valid && s_ready) encode_byte(s_data, s_last);
      if (m_valid && m_ready) begin
        beats_out++;
        if (symbols_due.size() == 0) begin
          flag_mismatch($sformatf("symbol %h last %b with nothing expected", m_data, m_last));
        end else begin
          due = symbols_due.pop_front();
          if (m_data[6:0] !== due.symbol)
            flag_mismatch($sformatf("symbol %h, expected %h", m_data[6:0], due.symbol));
          if (m_data[7] !== 1'b0)
            flag_mismatch($sformatf("tdata bit 7 is %b", m_data[7]));
          if (m_last !== due.last_sym)
            flag_mismatch($sformatf("tlast %b, expected %b on symbol %h",
                                    m_last, due.last_sym, due.symbol));
        end
      end
      if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL crockford_base32_encoder");
        $finish;
      end
    end
  end

  initial begin
    push_beat(8'h00, 1'b1);
    push_beat(8'hFF, 1'b1);
    push_beat(8'hFF, 1'b0);
    push_beat(8'h00, 1'b1);
    push_beat(8'hA5, 1'b0);
    push_beat(8'h5A, 1'b0);
    push_beat(8'hFF, 1'b1);
    push_beat(8'h00, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(8'h80, 1'b0);
    push_beat(8'h01, 1'b1);
    for (int i = 0; i < 5; i++) push_beat(8'hFF, i == 4);
    for (int i = 0; i < 6; i++) push_beat(8'h01 << i, i == 5);
    while (queued_bytes < TargetBytes) begin
      if ($urandom_range(0, 9) == 0) push_message($urandom_range(13, 40));
      else push_message($urandom_range(1, 12));
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_pending.size() > 0 || s_valid) @(posedge clk_i);
    while (symbols_due.size() > 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (symbols_due.size() != 0)
      flag_mismatch($sformatf("%0d symbols never arrived", symbols_due.size()));
    if (mismatches == 0) begin
      $display("PASS crockford_base32_encoder");
    end else begin
      $display("FAIL crockford_base32_encoder");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/cb32enc_pkg.sv
hdl/crockford_base32_encoder.sv
hdl/cb32enc_checker.sv
bench/crockford_base32_encoder_test.sv
